@@ hdl/pidcm_pkg.sv @@
package pidcm_pkg;

	// fixed point format shared by inputs, gains, state and output
	localparam int FRAC_BITS = 8;

	localparam int IN_W      = 24;
	localparam int DATA_IN_W = 2 * IN_W;
	localparam int ERR_W     = IN_W + 1;
	localparam int CERR_W    = 26;
	localparam int DIFF_W    = CERR_W + 1;
	localparam int INTEG_W   = 32;
	localparam int GAIN_W    = 16;
	localparam int OUT_W     = 32;
	localparam int CFG_W     = GAIN_W;
	localparam int REG_IDX_W = 2;

	localparam int PP_W  = GAIN_W + 1 + CERR_W;
	localparam int PI_W  = GAIN_W + 1 + INTEG_W;
	localparam int PD_W  = GAIN_W + 1 + DIFF_W;
	localparam int ACC_W = PI_W + 2;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_SPEED = 2'd1,
		MODE_ANGLE = 2'd2,
		MODE_LINE  = 2'd3
	} mode_t;

	localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 2'd3;

	// error thresholds
	localparam logic signed [CERR_W-1:0] ONE_C  = CERR_W'(1 << FRAC_BITS);
	localparam logic signed [CERR_W-1:0] HALF_C = CERR_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [CERR_W-1:0] H180_C = CERR_W'(180 << FRAC_BITS);
	localparam logic signed [ERR_W-1:0]  H180_E = ERR_W'(180 << FRAC_BITS);

	// integral limits, one bit wider than the integral for the add
	localparam int ISUM_W = INTEG_W + 1;
	localparam logic signed [ISUM_W-1:0] L1000_I = ISUM_W'(1000 << FRAC_BITS);
	localparam logic signed [ISUM_W-1:0] L300_I  = ISUM_W'(300 << FRAC_BITS);
	localparam logic signed [ISUM_W-1:0] IMAX_I  = ISUM_W'(64'sd2147483647);
	localparam logic signed [ISUM_W-1:0] IMIN_I  = ISUM_W'(-64'sd2147483648);

	// output saturation
	localparam logic signed [ACC_W-1:0] OMAX_A = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] OMIN_A = ACC_W'(-64'sd2147483648);

	// angle wrap: a value v >= 0 taken mod (360 << FRAC_BITS) is the integer
	// part mod 360 with the fraction bits kept as they are
	localparam int WRAP_DEG = 360;
	localparam int P360_I   = WRAP_DEG << FRAC_BITS;
	localparam int H180_I   = 180 << FRAC_BITS;
	localparam int WRAP_K   = ((1 << IN_W) + H180_I) / P360_I + 1;
	localparam int WRAP_KP  = WRAP_K * P360_I;
	localparam int V_W      = 26;
	localparam int VH_W     = V_W - FRAC_BITS;
	localparam int SH       = VH_W + 9;
	localparam int RECIP_W  = SH - 7;
	localparam int Q_W      = VH_W - 8;
	localparam int REM_W    = 9;
	localparam longint unsigned RECIP_L =
		((longint'(1) << SH) + longint'(WRAP_DEG - 1)) / longint'(WRAP_DEG);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam logic signed [V_W:0] H180_V = (V_W + 1)'(H180_I);
	localparam logic signed [V_W:0] KP_V   = (V_W + 1)'(WRAP_KP);

endpackage

@@ hdl/pid_controller_multimode.sv @@
// Positional PID step with four error-conditioning modes, Q.FRAC_BITS fixed point.
// Pipeline: an accepted item passes seven registers, s1 to s6 and the result register.
// One item per cycle unless stalled; integral feedback closes in one stage (add + clamp).
// Stalls: the whole pipeline holds while the result register is full and not taken.
// Reset (arst_n low, asynchronous): config registers, integral and last error go to zero,
// all stages empty.
module pid_controller_multimode import pidcm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_IN_W-1:0] s_tdata,   // [23:0] setpoint, [47:24] measured
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata    // [31:0] drive
);

	// configuration registers
	mode_t             mode_q;
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;

	// controller state
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [CERR_W-1:0]  prev_q;

	// stage valids
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, out_valid_q;
	logic adv;

	// stage payloads
	logic signed [IN_W-1:0]   sp_s1, ms_s1;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [ERR_W-1:0]  err_s3;
	logic                     hi_s3, lo_s3;
	logic [VH_W-1:0]          vh_s3;
	logic [FRAC_BITS-1:0]     vl_s3;
	logic [Q_W-1:0]           q_s3;
	logic signed [CERR_W-1:0] err_s4;
	logic                     clr_s4;
	logic signed [DIFF_W-1:0] diff_s5;
	logic signed [PP_W-1:0]   pp_s6;
	logic signed [PI_W-1:0]   pi_s6;
	logic signed [PD_W-1:0]   pd_s6;
	logic [OUT_W-1:0]         drive_q;

	// combinational nets
	logic                         hi_c, lo_c;
	logic signed [V_W:0]          v_c;
	logic [VH_W+RECIP_W-1:0]      qprod_c;
	logic [VH_W-1:0]              rem_h_c;
	logic signed [CERR_W-1:0]     wrapped_c, e_raw_c, e_wrap_c, e_c;
	logic                         clr_c;
	logic signed [ISUM_W-1:0]     base_c, isum_c, ilo_c, ihi_c, inext_c;
	logic signed [PP_W-1:0]       pp_c;
	logic signed [PI_W-1:0]       pi_c;
	logic signed [PD_W-1:0]       pd_c;
	logic signed [ACC_W-1:0]      acc_c, accsh_c;
	logic [OUT_W-1:0]             drive_c;

	// one global stall: everything moves when the result register can take an item
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = drive_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				REG_GAIN_P: gain_p_q <= cfg_data;
				REG_GAIN_I: gain_i_q <= cfg_data;
				REG_GAIN_D: gain_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= s_tvalid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			out_valid_q <= valid_s6;
		end
	end

	// s2 -> s3: wrap preparation. Shift err to a non-negative v with the same
	// residue, then estimate the integer part divided by 360 by reciprocal.
	// The reciprocal is wide enough for the quotient to be exact.
	assign hi_c    = err_s2 > H180_E;
	assign lo_c    = err_s2 < -H180_E;
	assign v_c     = (V_W + 1)'(err_s2) + H180_V - $signed((V_W + 1)'(hi_c))
	                 + (lo_c ? KP_V : '0);
	assign qprod_c = v_c[V_W-1:FRAC_BITS] * RECIP;

	// s3 -> s4: remainder and per-mode conditioning
	assign rem_h_c   = vh_s3 - VH_W'(q_s3) * VH_W'(WRAP_DEG);
	assign wrapped_c = $signed(CERR_W'({rem_h_c[REM_W-1:0], vl_s3})) - H180_C
	                   + $signed(CERR_W'(hi_s3));
	assign e_raw_c   = CERR_W'(err_s3);
	assign e_wrap_c  = (hi_s3 || lo_s3) ? wrapped_c : e_raw_c;

	always_comb begin
		e_c   = e_raw_c;
		clr_c = 1'b0;
		case (mode_q)
			MODE_SPEED: begin
				if (e_raw_c < HALF_C && e_raw_c > -HALF_C) e_c = '0;
			end
			MODE_ANGLE: begin
				e_c = e_wrap_c;
				// small angle error: drop it and restart the integral
				if (e_wrap_c > -ONE_C && e_wrap_c < ONE_C) begin
					e_c   = '0;
					clr_c = 1'b1;
				end
			end
			MODE_LINE: begin
				if (e_raw_c < ONE_C && e_raw_c > -ONE_C) e_c = ONE_C;
			end
			default: ;
		endcase
	end

	// s4 -> s5: integral add and clamp; integral and last error are the feedback loops
	always_comb begin
		case (mode_q)
			MODE_SPEED, MODE_LINE: begin
				ilo_c = -L1000_I;
				ihi_c = L1000_I;
			end
			MODE_ANGLE: begin
				ilo_c = -L300_I;
				ihi_c = L300_I;
			end
			default: begin
				ilo_c = IMIN_I;
				ihi_c = IMAX_I;
			end
		endcase
	end

	assign base_c  = clr_s4 ? '0 : ISUM_W'(integ_q);
	assign isum_c  = base_c + ISUM_W'(err_s4);
	assign inext_c = (isum_c < ilo_c) ? ilo_c : ((isum_c > ihi_c) ? ihi_c : isum_c);

	// integral and last error are written as the item enters s5, so while
	// it sits in s5 they hold exactly its values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else if (valid_s4 && adv) begin
			integ_q <= inext_c[INTEG_W-1:0];
			prev_q  <= err_s4;
		end
	end

	// s5 -> s6: three gain products in parallel
	assign pp_c = $signed({1'b0, gain_p_q}) * prev_q;
	assign pi_c = $signed({1'b0, gain_i_q}) * integ_q;
	assign pd_c = $signed({1'b0, gain_d_q}) * diff_s5;

	// s6 -> out: sum, floor shift, saturate
	assign acc_c   = ACC_W'(pp_s6) + ACC_W'(pi_s6) + ACC_W'(pd_s6);
	assign accsh_c = acc_c >>> FRAC_BITS;
	assign drive_c = (accsh_c > OMAX_A) ? OMAX_A[OUT_W-1:0]
	               : ((accsh_c < OMIN_A) ? OMIN_A[OUT_W-1:0] : accsh_c[OUT_W-1:0]);

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s1   <= $signed(s_tdata[IN_W-1:0]);
			ms_s1   <= $signed(s_tdata[DATA_IN_W-1:IN_W]);
			err_s2  <= ERR_W'(sp_s1) - ERR_W'(ms_s1);
			err_s3  <= err_s2;
			hi_s3   <= hi_c;
			lo_s3   <= lo_c;
			vh_s3   <= v_c[V_W-1:FRAC_BITS];
			vl_s3   <= v_c[FRAC_BITS-1:0];
			q_s3    <= qprod_c[SH +: Q_W];
			err_s4  <= e_c;
			clr_s4  <= clr_c;
			diff_s5 <= DIFF_W'(err_s4) - DIFF_W'(prev_q);
			pp_s6   <= pp_c;
			pi_s6   <= pi_c;
			pd_s6   <= pd_c;
			drive_q <= drive_c;
		end
	end

	// the reciprocal quotient must be exact: remainder below 360
	a_rem_exact: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (hi_s3 || lo_s3) |-> rem_h_c < VH_W'(WRAP_DEG))
		else $error("angle wrap remainder out of range");

	// wrapped angle error lands within +-180
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && mode_q == MODE_ANGLE |-> e_c <= H180_C && e_c >= -H180_C)
		else $error("angle error not wrapped");

	// line mode never passes a zero error on
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && mode_q == MODE_LINE |-> e_c != '0)
		else $error("line mode error is zero");

	// an angle update leaves the integral inside +-300
	a_angle_integ: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && adv && mode_q == MODE_ANGLE |=>
		ISUM_W'(integ_q) <= L300_I && ISUM_W'(integ_q) >= -L300_I)
		else $error("angle integral out of clamp");

endmodule
